// ===== src/stsi_pkg.sv =====
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared sizes and controller-to-datapath command type for the sorted table.
// ----------------------------------------------------------------------------
package stsi_pkg;

	// Table size and field widths
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// Width of the 1-based position before it is cut to the result field
	localparam int PSUM_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

	// Request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the incoming request
		logic exec;  // compare, update the table, register the result
	} stsi_cmd_t;

endpackage

// ===== src/stsi_req_if.sv =====
// ----------------------------------------------------------------------------
// stsi_req_if
// Request channel: valid/ready handshake carrying mode and value.
// ----------------------------------------------------------------------------
interface stsi_req_if;
	import stsi_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [DATA_W-1:0]  value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== src/stsi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stsi_rsp_if
// Response channel: valid/ready handshake carrying position, found, accepted.
// ----------------------------------------------------------------------------
interface stsi_rsp_if;
	import stsi_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             found;
	logic             accepted;

	modport source (output valid, output position, output found, output accepted, input ready);
	modport sink   (input valid, input position, input found, input accepted, output ready);
endinterface

// ===== src/stsi_datapath.sv =====
// ----------------------------------------------------------------------------
// stsi_datapath
// Row of compare-and-shift cells holding the sorted values, the fill count,
// the captured request and the response register.
// ----------------------------------------------------------------------------
module stsi_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stsi_pkg::stsi_cmd_t               cmd,
	input  logic                              in_mode,
	input  logic signed [stsi_pkg::DATA_W-1:0] in_value,
	output logic [stsi_pkg::POS_W-1:0]        position,
	output logic                              found,
	output logic                              accepted
);
	import stsi_pkg::*;

	logic signed [DATA_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]         count_q;
	logic                     mode_q;
	logic signed [DATA_W-1:0] value_q;
	logic [POS_W-1:0]         pos_q;
	logic                     found_q;
	logic                     accepted_q;

	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] hit;
	logic [CNT_W-1:0] idx;
	logic [CNT_W-1:0] sel_idx;
	logic             hit_any;
	logic             full;
	logic             do_ins;

	// Per-cell compares against the captured value
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt[i]  = (CNT_W'(i) < count_q) && (entries_q[i] < value_q);
			hit[i] = (CNT_W'(i) < count_q) &&
			         ((mode_q == MODE_SEARCH) ? (entries_q[i] == value_q) : !lt[i]);
		end
	end

	// First hit; falls back to the count (append or not found)
	always_comb begin
		idx     = count_q;
		hit_any = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				idx     = CNT_W'(i);
				hit_any = 1'b1;
			end
		end
	end

	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_ins  = cmd.exec && (mode_q == MODE_INSERT) && !full;
	assign sel_idx = ((mode_q == MODE_INSERT) && full) ? count_q : idx;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			value_q <= in_value;
		end
	end

	// Cell 0: takes the new value when it lands at the head
	always_ff @(posedge clk) begin
		if (do_ins && idx == '0)
			entries_q[0] <= value_q;
	end

	// Remaining cells: take the new value or shift up from the neighbor below
	for (genvar g = 1; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (CNT_W'(g) == idx)
					entries_q[g] <= value_q;
				else if (CNT_W'(g) > idx && CNT_W'(g) <= count_q)
					entries_q[g] <= entries_q[g-1];
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pos_q      <= POS_W'(PSUM_W'(sel_idx) + PSUM_W'(1));
			found_q    <= (mode_q == MODE_SEARCH) && hit_any;
			accepted_q <= (mode_q == MODE_INSERT) && !full;
		end
	end

	assign position = pos_q;
	assign found    = found_q;
	assign accepted = accepted_q;

endmodule

// ===== src/stsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// stsi_ctrl
// Two-state controller: take a request, then run it once the response
// register is free. Owns the response valid flag.
// ----------------------------------------------------------------------------
module stsi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output stsi_pkg::stsi_cmd_t cmd
);
	import stsi_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC) && slot_free;
	assign out_valid = out_valid_q;

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/sorted_table_insert_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// Sorted table of signed values with insert and search requests.
// ----------------------------------------------------------------------------
// Holds up to DEPTH (16) signed 32-bit values in ascending order in a row of
// compare-and-shift cells. An insert places the value ahead of the first
// stored value that is not smaller and reports its 1-based position; on a
// full table it is dropped with accepted low and position DEPTH+1. A search
// reports the 1-based position of the first equal value, or count+1 with
// found low. Each request is first captured and then executed: all cells
// compare in parallel, the table shifts and the response is registered;
// the response register lets the next request in while a response still
// waits to be taken. Positions wrap modulo 32.
module sorted_table_insert_search (
	input  logic         clk,
	input  logic         arst_n,
	stsi_req_if.sink     req,
	stsi_rsp_if.source   rsp
);
	import stsi_pkg::*;

	stsi_cmd_t cmd;

	stsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	stsi_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_mode  (req.mode),
		.in_value (req.value),
		.position (rsp.position),
		.found    (rsp.found),
		.accepted (rsp.accepted)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Randomized check of the sorted table insert/search block.
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed opening on an empty
// and a partly filled table, then random inserts and searches. The random
// part draws values from the extremes, from a narrow band that yields
// duplicates, from neighbors of stored values, and from the full 32-bit
// range. A clocked driver sends the requests with random gaps. A clocked
// monitor takes the responses with random stalls. Each accepted request
// updates a local copy of the table, and the response that copy predicts is
// queued. Every response is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import stsi_pkg::*;

	localparam int N_RANDOM   = 1780;
	localparam int TAIL_ITEMS = 150;   // no idling over the last requests
	localparam int WD_LIMIT   = 3000;  // cycles with no handshake at all
	localparam int DRAIN_WAIT = 8;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] value;
		logic                     wait_idle;  // hold until all responses are back
	} request_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             accepted;
	} result_t;

	typedef struct packed {
		logic    mode;
		result_t res;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	stsi_req_if req_ch ();
	stsi_rsp_if rsp_ch ();

	sorted_table_insert_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Request stream and its bookkeeping
	request_t                 pending_reqs[$];
	outcome_t                 predicted[$];
	logic signed [DATA_W-1:0] queued_vals[$];  // values the stream will store

	// Local copy of the table
	logic signed [DATA_W-1:0] held[DEPTH];
	int                       held_cnt = 0;

	int  n_sent = 0;
	int  n_checked = 0;
	int  err_cnt = 0;
	int  idle_cycles = 0;
	int  gap = 0;
	int  stall = 0;
	bit  jitter_on = 1'b1;
	int  n_stored = 0, n_dropped = 0, n_hits = 0, n_misses = 0;

	// Apply one request to the local table and return its response
	function automatic result_t table_apply(input logic mode,
	                                        input logic signed [DATA_W-1:0] v);
		result_t r;
		int      i;
		int      k;
		r = '0;
		i = 0;
		if (mode == MODE_INSERT) begin
			if (held_cnt >= DEPTH) begin
				r.position = POS_W'(DEPTH + 1);
			end else begin
				// new value goes ahead of equal ones
				while (i < held_cnt && held[i] < v)
					i++;
				for (k = held_cnt; k > i; k--)
					held[k] = held[k - 1];
				held[i] = v;
				held_cnt++;
				r.position = POS_W'(i + 1);
				r.accepted = 1'b1;
			end
		end else begin
			while (i < held_cnt && held[i] != v)
				i++;
			r.position = POS_W'(i + 1);
			r.found    = (i < held_cnt);
		end
		return r;
	endfunction

	task automatic add_req(input logic mode, input logic signed [DATA_W-1:0] v,
	                       input bit wait_idle);
		request_t q;
		q.mode      = mode;
		q.value     = v;
		q.wait_idle = wait_idle;
		pending_reqs.push_back(q);
		if (mode == MODE_INSERT && queued_vals.size() < DEPTH)
			queued_vals.push_back(v);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom;
			3, 4:    v = int'($urandom_range(0, 16)) - 8;
			5: begin
				case ($urandom_range(0, 3))
					0:       v = VAL_MIN;
					1:       v = VAL_MAX;
					2:       v = VAL_MIN + 1;
					default: v = VAL_MAX - 1;
				endcase
			end
			default: begin
				if (queued_vals.size() != 0)
					v = queued_vals[$urandom_range(0, queued_vals.size() - 1)]
					    + (int'($urandom_range(0, 2)) - 1);
				else
					v = $urandom;
			end
		endcase
		return v;
	endfunction

	// Driver: predicts on each accepted request, then presents the next one
	always @(posedge clk or negedge arst_n) begin : drive_req
		request_t nxt;
		int       sent_now;
		bit       jit;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode  <= MODE_INSERT;
			req_ch.value <= '0;
			gap          <= 0;
		end else begin
			sent_now = n_sent;
			jit      = jitter_on;
			if (req_ch.valid && req_ch.ready) begin
				predicted.push_back({req_ch.mode, table_apply(req_ch.mode, req_ch.value)});
				sent_now++;
				n_sent <= sent_now;
				// switch between noisy and quiet stretches
				if (sent_now % 64 == 0)
					jit = ($urandom_range(0, 3) != 0);
			end
			if (pending_reqs.size() < TAIL_ITEMS)
				jit = 1'b0;
			jitter_on <= jit;

			if (req_ch.valid && !req_ch.ready) begin
				// request still offered, hold it
			end else if (gap != 0) begin
				gap          <= gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() == 0 ||
			             (pending_reqs[0].wait_idle && sent_now != n_checked)) begin
				req_ch.valid <= 1'b0;
			end else if (jit && $urandom_range(0, 7) == 0) begin
				gap          <= $urandom_range(1, 15) - 1;
				req_ch.valid <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.mode  <= nxt.mode;
				req_ch.value <= nxt.value;
			end
		end
	end

	// Monitor: checks each response against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		outcome_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall        <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_checked <= n_checked + 1;
				if (predicted.size() == 0) begin
					$error("response with no request pending: position=%0d found=%0b accepted=%0b",
					       rsp_ch.position, rsp_ch.found, rsp_ch.accepted);
					err_cnt++;
				end else begin
					want = predicted.pop_front();
					if (rsp_ch.position !== want.res.position) begin
						$error("position: expected %0d, got %0d", want.res.position, rsp_ch.position);
						err_cnt++;
					end
					if (rsp_ch.found !== want.res.found) begin
						$error("found: expected %0b, got %0b", want.res.found, rsp_ch.found);
						err_cnt++;
					end
					if (rsp_ch.accepted !== want.res.accepted) begin
						$error("accepted: expected %0b, got %0b", want.res.accepted, rsp_ch.accepted);
						err_cnt++;
					end
					if (want.mode == MODE_INSERT) begin
						if (want.res.accepted) n_stored++;
						else n_dropped++;
					end else begin
						if (want.res.found) n_hits++;
						else n_misses++;
					end
				end
			end
			if (stall != 0) begin
				stall        <= stall - 1;
				rsp_ch.ready <= 1'b0;
			end else if (jitter_on && $urandom_range(0, 5) == 0) begin
				stall        <= $urandom_range(1, 15) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < WD_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", WD_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic                     mode;
		logic signed [DATA_W-1:0] v;
		req_ch.valid = 1'b0;
		req_ch.mode  = MODE_INSERT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		arst_n       = 1'b0;

		// searches on an empty table
		add_req(MODE_SEARCH, 0, 1'b0);
		add_req(MODE_SEARCH, VAL_MIN, 1'b0);
		// inserts at head, tail, middle, and ahead of an equal value
		add_req(MODE_INSERT, 0, 1'b0);
		add_req(MODE_INSERT, VAL_MIN, 1'b0);
		add_req(MODE_INSERT, VAL_MAX, 1'b0);
		add_req(MODE_INSERT, 0, 1'b0);
		add_req(MODE_INSERT, -1, 1'b0);
		add_req(MODE_INSERT, 1, 1'b0);
		// first-equal hits at both ends and in the middle, plus a miss
		add_req(MODE_SEARCH, 0, 1'b0);
		add_req(MODE_SEARCH, VAL_MIN, 1'b0);
		add_req(MODE_SEARCH, VAL_MAX, 1'b0);
		add_req(MODE_SEARCH, 5, 1'b0);
		add_req(MODE_SEARCH, -1, 1'b0);
		add_req(MODE_INSERT, VAL_MIN, 1'b0);
		add_req(MODE_INSERT, VAL_MAX, 1'b0);
		add_req(MODE_INSERT, 32'sh5555_5555, 1'b0);
		add_req(MODE_INSERT, 32'shAAAA_AAAA, 1'b0);
		add_req(MODE_SEARCH, 32'sh5555_5555, 1'b0);
		add_req(MODE_SEARCH, 32'shAAAA_AAAA, 1'b0);
		add_req(MODE_SEARCH, 7, 1'b0);

		// random part; even mix of inserts and searches until the table fills, then mostly searches
		for (int n = 0; n < N_RANDOM; n++) begin
			if (queued_vals.size() < DEPTH)
				mode = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_SEARCH;
			else
				mode = ($urandom_range(0, 4) == 0) ? MODE_INSERT : MODE_SEARCH;
			if (mode == MODE_SEARCH && queued_vals.size() != 0 && $urandom_range(0, 1) == 0)
				v = queued_vals[$urandom_range(0, queued_vals.size() - 1)];
			else
				v = pick_value();
			add_req(mode, v, (n == 0 || n == N_RANDOM / 2));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all requests out, all responses back, then let the pipe settle
		@(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || n_sent != n_checked)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (predicted.size() != 0) begin
			$error("%0d predicted responses never arrived", predicted.size());
			err_cnt++;
		end
		$display("run: %0d requests; inserts stored %0d, dropped on full table %0d",
		         n_sent, n_stored, n_dropped);
		$display("run: searches found %0d, not found %0d", n_hits, n_misses);
		if (err_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
src/stsi_pkg.sv
src/stsi_req_if.sv
src/stsi_rsp_if.sv
src/stsi_datapath.sv
src/stsi_ctrl.sv
src/sorted_table_insert_search.sv
test/tb_top.sv
